@@ sv/spz_pkg.sv @@
// Shared constants, types and sequencer states for the Spritz stream cipher.
package spz_pkg;

	localparam int STATE_SIZE = 256;
	localparam int ADDR_W     = $clog2(STATE_SIZE);
	localparam int BYTE_W     = 8;
	localparam int NIB_W      = 4;
	localparam int CNT_W      = $clog2(2 * STATE_SIZE + 1);

	localparam logic [CNT_W-1:0]  WHIP_UPDS    = CNT_W'(2 * STATE_SIZE);
	localparam logic [CNT_W-1:0]  CRUSH_STEPS  = CNT_W'(STATE_SIZE / 2);
	localparam logic [ADDR_W-1:0] HALF_IDX     = ADDR_W'(STATE_SIZE / 2);
	localparam logic [ADDR_W-1:0] NIBBLE_MASK  = ADDR_W'(8'h0F);
	localparam logic [BYTE_W-1:0] STRIDE_INIT  = BYTE_W'(1);
	localparam logic [BYTE_W-1:0] STRIDE_STEP  = BYTE_W'(2);
	localparam logic [2:0]        LAST_PHASE   = 3'd4;
	localparam logic [1:0]        KEY_NIBBLES  = 2'd2;
	localparam logic              KIND_KEY     = 1'b0;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_NEXT,
		ST_ABS0,
		ST_ABS1,
		ST_ABS2,
		ST_ABS3,
		ST_UPD0,
		ST_UPD1,
		ST_UPD2,
		ST_UPD3,
		ST_UPD4,
		ST_SQZ0,
		ST_SQZ1,
		ST_SQZ2,
		ST_SQZ3,
		ST_CR0,
		ST_CR1,
		ST_CR2,
		ST_CR3
	} spz_state_t;

	typedef struct packed {
		logic              clear;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [BYTE_W-1:0] wr_data;
		logic [ADDR_W-1:0] rd_addr;
	} spz_mem_req_t;

endpackage

@@ sv/spz_in_if.sv @@
// Input channel: one byte beat with its kind and restart flags.
interface spz_in_if;
	import spz_pkg::*;

	logic              valid;
	logic              ready;
	logic              kind;
	logic              restart;
	logic [BYTE_W-1:0] data_byte;

	modport source(output valid, kind, restart, data_byte, input ready);
	modport sink(input valid, kind, restart, data_byte, output ready);
endinterface

@@ sv/spz_out_if.sv @@
// Output channel: one ciphered byte beat.
interface spz_out_if;
	import spz_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;

	modport source(output valid, out_byte, input ready);
	modport sink(input valid, out_byte, output ready);
endinterface

@@ sv/spritz_stream_cipher.sv @@
// Spritz (N=256) stream cipher: sequencer around one single-port permutation store.
//
// Each accepted beat is handled alone and the input is not ready until it is done.
// Every permutation access goes through one store with a registered read, so the
// rate is set by the chain of dependent reads: a message byte with nothing absorbed
// takes an update and then a squeeze, a key byte two nibble exchanges. A shuffle,
// run by the first message byte after key bytes and before a nibble when 128 nibbles
// are pending, adds three whips of 512 updates and two crushes of 128 steps. Reset
// and restart bring the permutation back to the identity at once, with no clearing
// pass. A finished byte waits in an output register; a new message byte stalls only
// in its last step if that register is still full.
module spritz_stream_cipher (
	input  logic       clk,
	input  logic       arst_n,
	spz_in_if.sink     item,
	spz_out_if.source  result
);
	import spz_pkg::*;

	spz_state_t        state_q, state_d;
	logic [BYTE_W-1:0] i_q, i_d;
	logic [BYTE_W-1:0] j_q, j_d;
	logic [BYTE_W-1:0] k_q, k_d;
	logic [BYTE_W-1:0] z_q, z_d;
	logic [BYTE_W-1:0] w_q, w_d;
	logic [BYTE_W-1:0] a_q, a_d;
	logic              kind_q, kind_d;
	logic [BYTE_W-1:0] data_q, data_d;
	logic [1:0]        nib_q, nib_d;
	logic              shuf_q, shuf_d;
	logic [2:0]        phase_q, phase_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [BYTE_W-1:0] tmp_q, tmp_d;
	logic              out_vld_q, out_vld_d;
	logic [BYTE_W-1:0] out_byte_q, out_byte_d;

	spz_mem_req_t      mem_req;
	logic [BYTE_W-1:0] mem_rd;
	logic [NIB_W-1:0]  nib_val;
	logic [ADDR_W-1:0] nib_addr;
	logic [ADDR_W-1:0] crush_lo;

	spz_perm_mem u_perm_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mem_req),
		.rd_data (mem_rd)
	);

	assign item.ready      = (state_q == ST_IDLE);
	assign result.valid    = out_vld_q;
	assign result.out_byte = out_byte_q;

	assign nib_val  = nib_q[0] ? data_q[BYTE_W-1:NIB_W] : data_q[NIB_W-1:0];
	assign nib_addr = HALF_IDX | (ADDR_W'(nib_val) & NIBBLE_MASK);
	assign crush_lo = ADDR_W'(cnt_q[ADDR_W-2:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			i_q       <= '0;
			j_q       <= '0;
			k_q       <= '0;
			z_q       <= '0;
			w_q       <= STRIDE_INIT;
			a_q       <= '0;
			kind_q    <= 1'b0;
			nib_q     <= '0;
			shuf_q    <= 1'b0;
			phase_q   <= '0;
			cnt_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			i_q       <= i_d;
			j_q       <= j_d;
			k_q       <= k_d;
			z_q       <= z_d;
			w_q       <= w_d;
			a_q       <= a_d;
			kind_q    <= kind_d;
			nib_q     <= nib_d;
			shuf_q    <= shuf_d;
			phase_q   <= phase_d;
			cnt_q     <= cnt_d;
			out_vld_q <= out_vld_d;
		end
	end

	always_ff @(posedge clk) begin
		data_q     <= data_d;
		tmp_q      <= tmp_d;
		out_byte_q <= out_byte_d;
	end

	always_comb begin
		state_d    = state_q;
		i_d        = i_q;
		j_d        = j_q;
		k_d        = k_q;
		z_d        = z_q;
		w_d        = w_q;
		a_d        = a_q;
		kind_d     = kind_q;
		data_d     = data_q;
		nib_d      = nib_q;
		shuf_d     = shuf_q;
		phase_d    = phase_q;
		cnt_d      = cnt_q;
		tmp_d      = tmp_q;
		out_byte_d = out_byte_q;
		out_vld_d  = out_vld_q && !result.ready;

		mem_req         = '0;

		case (state_q)
			ST_IDLE: begin
				if (item.valid) begin
					kind_d  = item.kind;
					data_d  = item.data_byte;
					nib_d   = '0;
					state_d = ST_NEXT;
					if (item.restart) begin
						i_d           = '0;
						j_d           = '0;
						k_d           = '0;
						z_d           = '0;
						a_d           = '0;
						w_d           = STRIDE_INIT;
						mem_req.clear = 1'b1;
					end
				end
			end
			ST_NEXT: begin
				if (shuf_q) begin
					if (!phase_q[0]) begin
						if (cnt_q != WHIP_UPDS) begin
							state_d = ST_UPD0;
						end else begin
							w_d   = w_q + STRIDE_STEP;
							cnt_d = '0;
							if (phase_q == LAST_PHASE) begin
								shuf_d  = 1'b0;
								a_d     = '0;
								phase_d = '0;
							end else begin
								phase_d = phase_q + 3'd1;
							end
						end
					end else begin
						if (cnt_q != CRUSH_STEPS) begin
							state_d = ST_CR0;
						end else begin
							cnt_d   = '0;
							phase_d = phase_q + 3'd1;
						end
					end
				end else if (kind_q == KIND_KEY) begin
					if (nib_q == KEY_NIBBLES) begin
						state_d = ST_IDLE;
					end else if (a_q == HALF_IDX) begin
						shuf_d  = 1'b1;
						phase_d = '0;
						cnt_d   = '0;
					end else begin
						state_d = ST_ABS0;
					end
				end else begin
					if (a_q != '0) begin
						shuf_d  = 1'b1;
						phase_d = '0;
						cnt_d   = '0;
					end else begin
						state_d = ST_UPD0;
					end
				end
			end
			ST_ABS0: begin
				mem_req.rd_addr = a_q;
				state_d         = ST_ABS1;
			end
			ST_ABS1: begin
				tmp_d           = mem_rd;
				mem_req.rd_addr = nib_addr;
				state_d         = ST_ABS2;
			end
			ST_ABS2: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = a_q;
				mem_req.wr_data = mem_rd;
				state_d         = ST_ABS3;
			end
			ST_ABS3: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = nib_addr;
				mem_req.wr_data = tmp_q;
				a_d             = a_q + BYTE_W'(1);
				nib_d           = nib_q + 2'd1;
				state_d         = ST_NEXT;
			end
			ST_UPD0: begin
				i_d             = i_q + w_q;
				mem_req.rd_addr = i_q + w_q;
				state_d         = ST_UPD1;
			end
			ST_UPD1: begin
				tmp_d           = mem_rd;
				mem_req.rd_addr = j_q + mem_rd;
				state_d         = ST_UPD2;
			end
			ST_UPD2: begin
				j_d             = k_q + mem_rd;
				mem_req.rd_addr = k_q + mem_rd;
				state_d         = ST_UPD3;
			end
			ST_UPD3: begin
				k_d             = i_q + k_q + mem_rd;
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = i_q;
				mem_req.wr_data = mem_rd;
				state_d         = ST_UPD4;
			end
			ST_UPD4: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = j_q;
				mem_req.wr_data = tmp_q;
				if (shuf_q) begin
					cnt_d   = cnt_q + CNT_W'(1);
					state_d = ST_NEXT;
				end else begin
					state_d = ST_SQZ0;
				end
			end
			ST_SQZ0: begin
				mem_req.rd_addr = z_q + k_q;
				state_d         = ST_SQZ1;
			end
			ST_SQZ1: begin
				mem_req.rd_addr = i_q + mem_rd;
				state_d         = ST_SQZ2;
			end
			ST_SQZ2: begin
				tmp_d           = mem_rd;
				mem_req.rd_addr = j_q + mem_rd;
				state_d         = ST_SQZ3;
			end
			ST_SQZ3: begin
				mem_req.rd_addr = j_q + tmp_q;
				if (!out_vld_q || result.ready) begin
					z_d        = mem_rd;
					out_byte_d = data_q ^ mem_rd;
					out_vld_d  = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_CR0: begin
				mem_req.rd_addr = crush_lo;
				state_d         = ST_CR1;
			end
			ST_CR1: begin
				tmp_d           = mem_rd;
				mem_req.rd_addr = ~crush_lo;
				state_d         = ST_CR2;
			end
			ST_CR2: begin
				if (tmp_q > mem_rd) begin
					mem_req.wr_en   = 1'b1;
					mem_req.wr_addr = crush_lo;
					mem_req.wr_data = mem_rd;
					state_d         = ST_CR3;
				end else begin
					cnt_d   = cnt_q + CNT_W'(1);
					state_d = ST_NEXT;
				end
			end
			ST_CR3: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = ~crush_lo;
				mem_req.wr_data = tmp_q;
				cnt_d           = cnt_q + CNT_W'(1);
				state_d         = ST_NEXT;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end
endmodule

@@ sv/spz_perm_mem.sv @@
// Permutation store: one write and one registered read per cycle, identity until written.
module spz_perm_mem (
	input  logic                              clk,
	input  logic                              arst_n,
	input  spz_pkg::spz_mem_req_t             req,
	output logic [spz_pkg::BYTE_W-1:0]        rd_data
);
	import spz_pkg::*;

	logic [BYTE_W-1:0]     mem_q [STATE_SIZE];
	logic [STATE_SIZE-1:0] vld_q;
	logic [BYTE_W-1:0]     rd_data_q;
	logic [ADDR_W-1:0]     rd_addr_q;
	logic                  rd_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (req.clear) begin
			vld_q <= '0;
		end else if (req.wr_en) begin
			vld_q[req.wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		rd_data_q <= mem_q[req.rd_addr];
		rd_addr_q <= req.rd_addr;
		rd_vld_q  <= vld_q[req.rd_addr];
	end

	assign rd_data = rd_vld_q ? rd_data_q : BYTE_W'(rd_addr_q);
endmodule

@@ sv/spz_checker.sv @@
// Port-level checks for the Spritz stream cipher, bound to its top level.
module spz_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [spz_pkg::BYTE_W-1:0] out_byte
);
	import spz_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte))
		else $error("stalled output beat changed or dropped");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after an accepted beat");

	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("output beat appeared while the block was idle");
endmodule

bind spritz_stream_cipher spz_checker u_spz_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (item.valid),
	.in_ready  (item.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_byte  (result.out_byte)
);

@@ tb/spritz_stream_cipher_test.sv @@
// Testbench for the Spritz stream cipher: directed table, random sessions, keystream predictor.
`timescale 1ns / 1ps

module spritz_stream_cipher_test;
	import spz_pkg::*;

	localparam logic KIND_MSG     = !KIND_KEY;
	localparam int   RANDOM_BEATS = 1250;
	localparam int   STALL_LIMIT  = 60000;
	localparam int   DRAIN_CYCLES = 100;

	typedef struct packed {
		logic              kind;
		logic              restart;
		logic [BYTE_W-1:0] data;
		logic              pinned;
		logic [BYTE_W-1:0] pin;
	} beat_t;

	logic clk = 1'b0;
	logic arst_n;

	spz_in_if  item ();
	spz_out_if result ();

	spritz_stream_cipher dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item.sink),
		.result (result.source)
	);

	always #5 clk = ~clk;

	// Keystream predictor state
	logic [BYTE_W-1:0] ks_perm [STATE_SIZE];
	logic [BYTE_W-1:0] ks_i, ks_j, ks_k, ks_z, ks_w, ks_a;

	logic [BYTE_W-1:0] cipher_due [$];
	logic              pin_on;
	logic [BYTE_W-1:0] pin_byte;
	int                mismatches = 0;
	int                quiet_cycles = 0;
	int                tx_calm = 0;
	int                rx_hold = 0;
	int                rx_calm = 0;

	beat_t plan [14] = '{
		'{KIND_MSG, 1'b0, 8'h00, 1'b1, 8'h04},
		'{KIND_MSG, 1'b1, 8'hFF, 1'b1, 8'hFB},
		'{KIND_MSG, 1'b0, 8'hA5, 1'b0, 8'h00},
		'{KIND_KEY, 1'b1, 8'h00, 1'b0, 8'h00},
		'{KIND_KEY, 1'b0, 8'hFF, 1'b0, 8'h00},
		'{KIND_KEY, 1'b0, 8'h0F, 1'b0, 8'h00},
		'{KIND_KEY, 1'b0, 8'hF0, 1'b0, 8'h00},
		'{KIND_MSG, 1'b0, 8'h00, 1'b0, 8'h00},
		'{KIND_MSG, 1'b0, 8'hFF, 1'b0, 8'h00},
		'{KIND_KEY, 1'b0, 8'h5A, 1'b0, 8'h00},
		'{KIND_MSG, 1'b0, 8'h3C, 1'b0, 8'h00},
		'{KIND_MSG, 1'b1, 8'h80, 1'b1, 8'h84},
		'{KIND_KEY, 1'b1, 8'h12, 1'b0, 8'h00},
		'{KIND_MSG, 1'b0, 8'h01, 1'b0, 8'h00}
	};

	function automatic void ks_swap(input logic [BYTE_W-1:0] p, input logic [BYTE_W-1:0] q);
		logic [BYTE_W-1:0] t;
		t = ks_perm[p];
		ks_perm[p] = ks_perm[q];
		ks_perm[q] = t;
	endfunction

	function automatic void ks_reload();
		for (int v = 0; v < STATE_SIZE; v++)
			ks_perm[v] = BYTE_W'(v);
		ks_i = '0;
		ks_j = '0;
		ks_k = '0;
		ks_z = '0;
		ks_a = '0;
		ks_w = STRIDE_INIT;
	endfunction

	function automatic void ks_update();
		ks_i = ks_i + ks_w;
		ks_j = ks_k + ks_perm[BYTE_W'(ks_j + ks_perm[ks_i])];
		ks_k = ks_i + ks_k + ks_perm[ks_j];
		ks_swap(ks_i, ks_j);
	endfunction

	function automatic void ks_whip();
		for (int v = 0; v < 2 * STATE_SIZE; v++)
			ks_update();
		ks_w = ks_w + STRIDE_STEP;
	endfunction

	function automatic void ks_crush();
		for (int v = 0; v < STATE_SIZE / 2; v++) begin
			if (ks_perm[v] > ks_perm[STATE_SIZE - 1 - v])
				ks_swap(BYTE_W'(v), BYTE_W'(STATE_SIZE - 1 - v));
		end
	endfunction

	function automatic void ks_shuffle();
		ks_whip();
		ks_crush();
		ks_whip();
		ks_crush();
		ks_whip();
		ks_a = '0;
	endfunction

	function automatic void ks_absorb_nibble(input logic [NIB_W-1:0] x);
		if (ks_a >= HALF_IDX)
			ks_shuffle();
		ks_swap(ks_a, HALF_IDX + BYTE_W'(x));
		ks_a = ks_a + 1'b1;
	endfunction

	// Advance the cipher by one beat; return 1 with the ciphered byte for a message beat.
	function automatic bit cipher_next(input logic kind, input logic restart,
			input logic [BYTE_W-1:0] data, output logic [BYTE_W-1:0] ct);
		logic [BYTE_W-1:0] t;
		ct = '0;
		if (restart)
			ks_reload();
		if (kind == KIND_KEY) begin
			ks_absorb_nibble(data[3:0]);
			ks_absorb_nibble(data[7:4]);
			return 1'b0;
		end
		if (ks_a != 0)
			ks_shuffle();
		ks_update();
		t = ks_perm[BYTE_W'(ks_z + ks_k)];
		t = ks_perm[BYTE_W'(ks_i + t)];
		ks_z = ks_perm[BYTE_W'(ks_j + t)];
		ct = data ^ ks_z;
		return 1'b1;
	endfunction

	function automatic int idle_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 3);
	endfunction

	task automatic send_beat(input beat_t b);
		if (tx_calm > 0) begin
			tx_calm--;
		end else if ($urandom_range(0, 2) == 0) begin
			item.valid <= 1'b0;
			repeat (idle_len()) @(posedge clk);
		end else if ($urandom_range(0, 30) == 0) begin
			tx_calm = $urandom_range(20, 150);
		end
		item.valid     <= 1'b1;
		item.kind      <= b.kind;
		item.restart   <= b.restart;
		item.data_byte <= b.data;
		pin_on         <= b.pinned;
		pin_byte       <= b.pin;
		do @(posedge clk); while (!item.ready);
	endtask

	// Random stalls on the result side
	always @(posedge clk) begin
		if (rx_hold > 1) begin
			rx_hold <= rx_hold - 1;
		end else if (rx_hold == 1) begin
			rx_hold <= 0;
			result.ready <= 1'b1;
		end else if (rx_calm > 0) begin
			rx_calm <= rx_calm - 1;
		end else if ($urandom_range(0, 3) == 0) begin
			rx_hold <= idle_len();
			result.ready <= 1'b0;
		end else if ($urandom_range(0, 30) == 0) begin
			rx_calm <= $urandom_range(20, 150);
		end
	end

	always @(posedge clk) begin
		logic [BYTE_W-1:0] ct;
		logic [BYTE_W-1:0] want;
		if (arst_n) begin
			if (item.valid && item.ready) begin
				if (cipher_next(item.kind, item.restart, item.data_byte, ct))
					cipher_due.push_back(pin_on ? pin_byte : ct);
			end
			if (result.valid && result.ready) begin
				if (cipher_due.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected out_byte, expected none, actual %h",
						$time, result.out_byte);
				end else begin
					want = cipher_due.pop_front();
					if (result.out_byte !== want) begin
						mismatches++;
						$display("%0t: out_byte expected %h, actual %h",
							$time, want, result.out_byte);
					end
				end
			end
			if ((item.valid && item.ready) || (result.valid && result.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		int    sent;
		int    keys;
		int    msgs;
		bit    restart_first;
		beat_t b;
		arst_n         = 1'b0;
		item.valid     = 1'b0;
		item.kind      = KIND_KEY;
		item.restart   = 1'b0;
		item.data_byte = '0;
		result.ready   = 1'b1;
		pin_on         = 1'b0;
		pin_byte       = '0;
		ks_reload();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[n])
			send_beat(plan[n]);

		sent = 0;
		for (int s = 0; sent < RANDOM_BEATS; s++) begin
			restart_first = ($urandom_range(0, 5) != 0);
			if (s == 2 || $urandom_range(0, 24) == 0)
				keys = $urandom_range(65, 72);
			else
				keys = $urandom_range(0, 8);
			msgs = $urandom_range(10, 45);
			for (int n = 0; n < keys + msgs; n++) begin
				b = '{(n < keys) ? KIND_KEY : KIND_MSG, (n == 0) && restart_first,
					BYTE_W'($urandom), 1'b0, 8'h00};
				if ($urandom_range(0, 49) == 0) begin
					b.kind    = 1'($urandom);
					b.restart = 1'($urandom);
				end
				send_beat(b);
				sent++;
			end
		end
		item.valid <= 1'b0;

		while (cipher_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/spz_pkg.sv
sv/spz_in_if.sv
sv/spz_out_if.sv
sv/spz_perm_mem.sv
sv/spritz_stream_cipher.sv
sv/spz_checker.sv
tb/spritz_stream_cipher_test.sv
